[hw/rtl/rog_pkg.sv]
// Shared types, codes and helpers for the rectangle occupancy grid engine.
// Used by the front classifier, the job queue, the back sequencer and the top level.
// Depends on nothing else.
package rog_pkg;

    localparam int COORD_BITS = 14;
    localparam int MAX_PHASES = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int MIN_GRID = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam logic [2:0] REQ_PAINT     = 3'd0;
    localparam logic [2:0] REQ_PROBE     = 3'd1;
    localparam logic [2:0] REQ_SHIFT     = 3'd2;
    localparam logic [2:0] REQ_MOVE_TO   = 3'd3;
    localparam logic [2:0] REQ_CLEAR_ALL = 3'd4;
    localparam logic [2:0] REQ_READ_CELL = 3'd5;

    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_UP    = 3'd1;
    localparam logic [2:0] DIR_DOWN  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_CLEAR_INT,
        PH_CLEAR_ALL,
        PH_SCAN
    } phase_kind_t;

    typedef struct packed {
        phase_kind_t kind;
        logic        write_id;
        logic        col_major;
        coord_t      r_first;
        coord_t      r_last;
        logic        r_down;
        coord_t      c_first;
        coord_t      c_last;
        logic        c_down;
    } phase_t;

    typedef struct packed {
        phase_t [MAX_PHASES-1:0] ph;
        logic [1:0]              n_ph;
        logic [7:0]              id;
        logic                    preset_border;
        logic                    bad_dir;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_RUN,
        BK_FINISH,
        BK_DONE
    } back_state_t;

    function automatic logic is_interior(coord_t c, coord_t r, coord_t uw, coord_t uh);
        return (c > 0) && (r > 0) && (c < uw - coord_t'(1)) && (r < uh - coord_t'(1));
    endfunction

    function automatic phase_t mk_phase(phase_kind_t kind, logic write_id, logic col_major,
                                        coord_t r_first, coord_t r_last, logic r_down,
                                        coord_t c_first, coord_t c_last, logic c_down);
        phase_t p;
        p.kind = kind;
        p.write_id = write_id;
        p.col_major = col_major;
        p.r_first = r_first;
        p.r_last = r_last;
        p.r_down = r_down;
        p.c_first = c_first;
        p.c_last = c_last;
        p.c_down = c_down;
        return p;
    endfunction

endpackage

[hw/rtl/rect_occupancy_grid_engine.sv]
// Top level of the rectangle occupancy grid engine: configuration registers and block wiring.
// Depends on rog_pkg, rog_front, rog_queue, rog_back and rog_ram.
//
//   Channel   Handshake             Payload
//   request   req_valid/req_stall   req_type .. target_y
//   response  rsp_valid/rsp_stall   hit_object, bad_direction
//   config    APB psel/penable      paddr, pwdata, prdata
//
// A request walks the cells of its phases one cell per cycle.
// The rate is set by the grid memory, whose write port and read port share one address.
// After reset a clearing pass over all MAX_ROWS*MAX_COLUMNS cells runs; req_stall is high meanwhile.
// clear_all walks the same cells. Up to two transactions queue behind a busy walk.
module rect_occupancy_grid_engine #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS = 256,
    parameter int ID_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  req_type,
    input  logic [7:0]  object_id,
    input  logic [7:0]  rect_x,
    input  logic [7:0]  rect_y,
    input  logic [8:0]  rect_w,
    input  logic [8:0]  rect_h,
    input  logic [2:0]  direction,
    input  logic [7:0]  move_distance,
    input  logic [7:0]  target_x,
    input  logic [7:0]  target_y,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [7:0]  hit_object,
    output logic        bad_direction,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_GRID_WIDTH = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    logic [8:0]      grid_width_reg, grid_width_next;
    logic [8:0]      grid_height_reg, grid_height_next;
    rog_pkg::coord_t used_w, used_h;
    logic            cfg_write, q_push, q_pop, q_full, q_empty, init_busy;
    rog_pkg::job_t   push_job, head_job;

    assign pready = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        grid_width_next = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  grid_width_next = pwdata[8:0];
                REG_GRID_HEIGHT: grid_height_next = pwdata[8:0];
                default:         grid_width_next = grid_width_reg;
            endcase
        end

        prdata = (paddr[2] == REG_GRID_HEIGHT) ? {23'd0, grid_height_reg}
                                               : {23'd0, grid_width_reg};

        if (grid_width_reg < 9'(rog_pkg::MIN_GRID))
        begin
            used_w = rog_pkg::coord_t'(rog_pkg::MIN_GRID);
        end
        else if (int'(grid_width_reg) > MAX_COLUMNS)
        begin
            used_w = rog_pkg::coord_t'(MAX_COLUMNS);
        end
        else
        begin
            used_w = rog_pkg::coord_t'(grid_width_reg);
        end

        if (grid_height_reg < 9'(rog_pkg::MIN_GRID))
        begin
            used_h = rog_pkg::coord_t'(rog_pkg::MIN_GRID);
        end
        else if (int'(grid_height_reg) > MAX_ROWS)
        begin
            used_h = rog_pkg::coord_t'(MAX_ROWS);
        end
        else
        begin
            used_h = rog_pkg::coord_t'(grid_height_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= 9'd256;
            grid_height_reg <= 9'd256;
        end
        else
        begin
            grid_width_reg <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    rog_front u_front (
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .object_id(object_id),
        .rect_x(rect_x),
        .rect_y(rect_y),
        .rect_w(rect_w),
        .rect_h(rect_h),
        .direction(direction),
        .move_distance(move_distance),
        .target_x(target_x),
        .target_y(target_y),
        .used_w(used_w),
        .used_h(used_h),
        .hold(init_busy),
        .q_full(q_full),
        .push(q_push),
        .job(push_job)
    );

    rog_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_job(push_job),
        .pop(q_pop),
        .head_job(head_job),
        .full(q_full),
        .empty(q_empty)
    );

    rog_back #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS(MAX_ROWS),
        .ID_BITS(ID_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_head(head_job),
        .q_pop(q_pop),
        .used_w(used_w),
        .used_h(used_h),
        .init_busy(init_busy),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .hit_object(hit_object),
        .bad_direction(bad_direction)
    );

endmodule

[hw/rtl/rog_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module rog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/rog_front.sv]
// Front classifier: accepts request transactions and turns each into a job of cell walks.
// Depends on rog_pkg.
module rog_front (
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [2:0]        req_type,
    input  logic [7:0]        object_id,
    input  logic [7:0]        rect_x,
    input  logic [7:0]        rect_y,
    input  logic [8:0]        rect_w,
    input  logic [8:0]        rect_h,
    input  logic [2:0]        direction,
    input  logic [7:0]        move_distance,
    input  logic [7:0]        target_x,
    input  logic [7:0]        target_y,
    input  rog_pkg::coord_t   used_w,
    input  rog_pkg::coord_t   used_h,
    input  logic              hold,
    input  logic              q_full,
    output logic              push,
    output rog_pkg::job_t     job
);

    rog_pkg::coord_t x, y, w, h, d, tx, ty, right, bottom, nr, nb, cx, cy;
    logic dir_bad;

    assign req_stall = q_full | hold;
    assign push = req_valid & ~req_stall;

    always_comb
    begin
        x = rog_pkg::coord_t'(rect_x);
        y = rog_pkg::coord_t'(rect_y);
        w = rog_pkg::coord_t'(rect_w);
        h = rog_pkg::coord_t'(rect_h);
        d = rog_pkg::coord_t'(move_distance);
        tx = rog_pkg::coord_t'(target_x);
        ty = rog_pkg::coord_t'(target_y);
        right = x + w - rog_pkg::coord_t'(1);
        bottom = y + h - rog_pkg::coord_t'(1);
        nr = tx + w - rog_pkg::coord_t'(1);
        nb = ty + h - rog_pkg::coord_t'(1);
        dir_bad = direction > rog_pkg::DIR_RIGHT;

        cx = x;
        cy = y;
        unique case (direction)
            rog_pkg::DIR_UP:    cy = y - d;
            rog_pkg::DIR_DOWN:  cy = bottom + d;
            rog_pkg::DIR_LEFT:  cx = x - d;
            rog_pkg::DIR_RIGHT: cx = right + d;
            default:
            begin
                cx = x;
                cy = y;
            end
        endcase

        job = '0;
        job.id = object_id;

        unique case (req_type)
            rog_pkg::REQ_PAINT:
            begin
                job.n_ph = 2'd1;
                job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_FILL, 1'b1, 1'b0,
                                              y, bottom, 1'b0, x, right, 1'b0);
            end
            rog_pkg::REQ_PROBE:
            begin
                if (dir_bad)
                begin
                    job.bad_dir = 1'b1;
                end
                else if (!rog_pkg::is_interior(cx, cy, used_w, used_h))
                begin
                    job.preset_border = 1'b1;
                end
                else
                begin
                    job.n_ph = 2'd1;
                    unique case (direction)
                        rog_pkg::DIR_UP:
                            job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_SCAN, 1'b0, 1'b0,
                                y - rog_pkg::coord_t'(1), y - d, 1'b1, x, right, 1'b0);
                        rog_pkg::DIR_DOWN:
                            job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_SCAN, 1'b0, 1'b0,
                                bottom + rog_pkg::coord_t'(1), bottom + d, 1'b0, x, right, 1'b0);
                        rog_pkg::DIR_LEFT:
                            job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_SCAN, 1'b0, 1'b1,
                                y, bottom, 1'b0, x - rog_pkg::coord_t'(1), x - d, 1'b1);
                        rog_pkg::DIR_RIGHT:
                            job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_SCAN, 1'b0, 1'b1,
                                y, bottom, 1'b0, right + rog_pkg::coord_t'(1), right + d, 1'b0);
                        default:
                            job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_SCAN, 1'b0, 1'b0,
                                y, y, 1'b0, x, x, 1'b0);
                    endcase
                end
            end
            rog_pkg::REQ_SHIFT:
            begin
                if (dir_bad)
                begin
                    job.bad_dir = 1'b1;
                end
                else
                begin
                    unique case (direction)
                        rog_pkg::DIR_UP:
                        begin
                            job.n_ph = 2'd2;
                            job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_FILL, 1'b1, 1'b0,
                                y - d, y - rog_pkg::coord_t'(1), 1'b0, x, right, 1'b0);
                            job.ph[1] = rog_pkg::mk_phase(rog_pkg::PH_FILL, 1'b0, 1'b0,
                                bottom - d + rog_pkg::coord_t'(1), bottom, 1'b0, x, right, 1'b0);
                        end
                        rog_pkg::DIR_DOWN:
                        begin
                            job.n_ph = 2'd2;
                            job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_FILL, 1'b1, 1'b0,
                                bottom + rog_pkg::coord_t'(1), bottom + d, 1'b0, x, right, 1'b0);
                            job.ph[1] = rog_pkg::mk_phase(rog_pkg::PH_FILL, 1'b0, 1'b0,
                                y, y + d - rog_pkg::coord_t'(1), 1'b0, x, right, 1'b0);
                        end
                        rog_pkg::DIR_LEFT:
                        begin
                            job.n_ph = 2'd2;
                            job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_FILL, 1'b1, 1'b0,
                                y, bottom, 1'b0, x - d, x - rog_pkg::coord_t'(1), 1'b0);
                            job.ph[1] = rog_pkg::mk_phase(rog_pkg::PH_FILL, 1'b0, 1'b0,
                                y, bottom, 1'b0, right - d + rog_pkg::coord_t'(1), right, 1'b0);
                        end
                        rog_pkg::DIR_RIGHT:
                        begin
                            job.n_ph = 2'd2;
                            job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_FILL, 1'b1, 1'b0,
                                y, bottom, 1'b0, right + rog_pkg::coord_t'(1), right + d, 1'b0);
                            job.ph[1] = rog_pkg::mk_phase(rog_pkg::PH_FILL, 1'b0, 1'b0,
                                y, bottom, 1'b0, x, x + d - rog_pkg::coord_t'(1), 1'b0);
                        end
                        default:
                        begin
                            job.n_ph = 2'd0;
                        end
                    endcase
                end
            end
            rog_pkg::REQ_MOVE_TO:
            begin
                job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_CLEAR_INT, 1'b0, 1'b0,
                                              y, bottom, 1'b0, x, right, 1'b0);
                if (rog_pkg::is_interior(tx, ty, used_w, used_h) &&
                    rog_pkg::is_interior(nr, ty, used_w, used_h) &&
                    rog_pkg::is_interior(tx, nb, used_w, used_h) &&
                    rog_pkg::is_interior(nr, nb, used_w, used_h))
                begin
                    job.n_ph = 2'd3;
                    job.ph[1] = rog_pkg::mk_phase(rog_pkg::PH_SCAN, 1'b0, 1'b0,
                                                  ty, nb, 1'b0, tx, nr, 1'b0);
                    job.ph[2] = rog_pkg::mk_phase(rog_pkg::PH_FILL, 1'b1, 1'b0,
                                                  ty, nb, 1'b0, tx, nr, 1'b0);
                end
                else
                begin
                    job.n_ph = 2'd1;
                    job.preset_border = 1'b1;
                end
            end
            rog_pkg::REQ_CLEAR_ALL:
            begin
                job.n_ph = 2'd1;
                job.ph[0].kind = rog_pkg::PH_CLEAR_ALL;
            end
            rog_pkg::REQ_READ_CELL:
            begin
                job.n_ph = 2'd1;
                job.ph[0] = rog_pkg::mk_phase(rog_pkg::PH_SCAN, 1'b0, 1'b0,
                                              ty, ty, 1'b0, tx, tx, 1'b0);
            end
            default:
            begin
                job.n_ph = 2'd0;
            end
        endcase
    end

endmodule

[hw/rtl/rog_queue.sv]
// Short job queue between the front classifier and the back sequencer.
// Depends on rog_pkg.
module rog_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rog_pkg::job_t push_job,
    input  logic          pop,
    output rog_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);

    localparam int DEPTH = rog_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    rog_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full = count_reg == (PTR_W + 1)'(DEPTH);
    assign empty = count_reg == '0;
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next = count_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/rog_back.sv]
// Back sequencer: walks the cells of each job phase over the grid memory and returns results.
// Depends on rog_pkg and rog_ram.
module rog_back #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS = 256,
    parameter int ID_BITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  rog_pkg::job_t   q_head,
    output logic            q_pop,
    input  rog_pkg::coord_t used_w,
    input  rog_pkg::coord_t used_h,
    output logic            init_busy,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output logic [7:0]      hit_object,
    output logic            bad_direction
);

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam rog_pkg::coord_t RST_W = rog_pkg::coord_t'((MAX_COLUMNS < 256) ? MAX_COLUMNS : 256);
    localparam rog_pkg::coord_t RST_H = rog_pkg::coord_t'((MAX_ROWS < 256) ? MAX_ROWS : 256);

    rog_pkg::back_state_t state_reg, state_next;
    rog_pkg::job_t        job_reg, job_next;
    rog_pkg::phase_t      ph_reg, ph_next, load_ph;
    logic [1:0]           p_reg, p_next, n_eff;
    rog_pkg::coord_t      cur_r_reg, cur_r_next, cur_c_reg, cur_c_next;
    rog_pkg::coord_t      dims_w_reg, dims_w_next, dims_h_reg, dims_h_next;
    logic [ID_BITS-1:0]   hit_reg, hit_next;
    logic                 found_reg, found_next;
    logic                 sweep_reg, sweep_next;
    logic                 vld_b_reg, vld_b_next, oob_b_reg, oob_b_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [7:0]           rsp_hit_reg, rsp_hit_next;
    logic                 rsp_bad_reg, rsp_bad_next;

    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_addr;
    logic [ID_BITS-1:0]   ram_wdata, ram_rdata, val_b;
    logic                 hit_now, in_grid, on_edge, interior, abort, load_empty;
    logic                 r_at_last, c_at_last;
    rog_pkg::coord_t      r_step, c_step;

    rog_ram #(
        .WIDTH(ID_BITS),
        .DEPTH(DEPTH)
    ) u_grid_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_addr),
        .wdata(ram_wdata),
        .re(ram_re),
        .raddr(ram_addr),
        .rdata(ram_rdata)
    );

    assign init_busy = sweep_reg;
    assign rsp_valid = rsp_valid_reg;
    assign hit_object = rsp_hit_reg;
    assign bad_direction = rsp_bad_reg;

    assign ram_addr = ADDR_W'(ADDR_W'($unsigned(cur_r_reg)) * ADDR_W'(MAX_COLUMNS))
                    + ADDR_W'($unsigned(cur_c_reg));

    always_comb
    begin
        val_b = oob_b_reg ? ID_BITS'(1) : ram_rdata;
        hit_now = vld_b_reg && !found_reg && (val_b != '0);

        in_grid = (cur_r_reg >= 0) && (cur_c_reg >= 0) &&
                  (cur_r_reg < dims_h_reg) && (cur_c_reg < dims_w_reg);
        on_edge = (cur_r_reg == 0) || (cur_c_reg == 0) ||
                  (cur_r_reg == dims_h_reg - rog_pkg::coord_t'(1)) ||
                  (cur_c_reg == dims_w_reg - rog_pkg::coord_t'(1));
        interior = rog_pkg::is_interior(cur_c_reg, cur_r_reg, dims_w_reg, dims_h_reg);
        r_at_last = cur_r_reg == ph_reg.r_last;
        c_at_last = cur_c_reg == ph_reg.c_last;
        r_step = ph_reg.r_down ? cur_r_reg - rog_pkg::coord_t'(1)
                               : cur_r_reg + rog_pkg::coord_t'(1);
        c_step = ph_reg.c_down ? cur_c_reg - rog_pkg::coord_t'(1)
                               : cur_c_reg + rog_pkg::coord_t'(1);

        n_eff = sweep_reg ? 2'd1 : job_reg.n_ph;
        load_ph = job_reg.ph[p_reg];
        if (sweep_reg || load_ph.kind == rog_pkg::PH_CLEAR_ALL)
        begin
            load_ph = rog_pkg::mk_phase(rog_pkg::PH_CLEAR_ALL, 1'b0, 1'b0,
                                        rog_pkg::coord_t'(0), rog_pkg::coord_t'(MAX_ROWS - 1),
                                        1'b0,
                                        rog_pkg::coord_t'(0), rog_pkg::coord_t'(MAX_COLUMNS - 1),
                                        1'b0);
        end
        load_empty = (load_ph.r_down ? (load_ph.r_first < load_ph.r_last)
                                     : (load_ph.r_first > load_ph.r_last)) ||
                     (load_ph.c_down ? (load_ph.c_first < load_ph.c_last)
                                     : (load_ph.c_first > load_ph.c_last));

        state_next = state_reg;
        job_next = job_reg;
        ph_next = ph_reg;
        p_next = p_reg;
        cur_r_next = cur_r_reg;
        cur_c_next = cur_c_reg;
        dims_w_next = dims_w_reg;
        dims_h_next = dims_h_reg;
        hit_next = hit_reg;
        found_next = found_reg;
        sweep_next = sweep_reg;
        vld_b_next = 1'b0;
        oob_b_next = oob_b_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_hit_next = rsp_hit_reg;
        rsp_bad_next = rsp_bad_reg;
        q_pop = 1'b0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_wdata = '0;
        abort = 1'b0;

        if (hit_now)
        begin
            hit_next = val_b;
            found_next = 1'b1;
        end
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            rog_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    job_next = q_head;
                    p_next = 2'd0;
                    hit_next = q_head.preset_border ? ID_BITS'(1) : '0;
                    found_next = 1'b0;
                    dims_w_next = used_w;
                    dims_h_next = used_h;
                    state_next = rog_pkg::BK_LOAD;
                end
            end
            rog_pkg::BK_LOAD:
            begin
                if (p_reg == n_eff)
                begin
                    state_next = rog_pkg::BK_FINISH;
                end
                else if (load_empty)
                begin
                    p_next = p_reg + 2'd1;
                end
                else
                begin
                    ph_next = load_ph;
                    cur_r_next = load_ph.r_first;
                    cur_c_next = load_ph.c_first;
                    state_next = rog_pkg::BK_RUN;
                end
            end
            rog_pkg::BK_RUN:
            begin
                unique case (ph_reg.kind)
                    rog_pkg::PH_FILL:
                    begin
                        ram_we = in_grid;
                        ram_wdata = ph_reg.write_id ? ID_BITS'(job_reg.id) : '0;
                    end
                    rog_pkg::PH_CLEAR_INT:
                    begin
                        ram_we = interior;
                    end
                    rog_pkg::PH_CLEAR_ALL:
                    begin
                        ram_we = 1'b1;
                        ram_wdata = (in_grid && on_edge) ? ID_BITS'(1) : '0;
                    end
                    rog_pkg::PH_SCAN:
                    begin
                        if (found_reg || hit_now)
                        begin
                            abort = 1'b1;
                        end
                        else
                        begin
                            ram_re = in_grid;
                            vld_b_next = 1'b1;
                            oob_b_next = !in_grid;
                        end
                    end
                    default:
                    begin
                        abort = 1'b1;
                    end
                endcase

                if (abort)
                begin
                    p_next = p_reg + 2'd1;
                    state_next = rog_pkg::BK_LOAD;
                end
                else if (ph_reg.col_major)
                begin
                    if (!r_at_last)
                    begin
                        cur_r_next = r_step;
                    end
                    else if (!c_at_last)
                    begin
                        cur_r_next = ph_reg.r_first;
                        cur_c_next = c_step;
                    end
                    else
                    begin
                        p_next = p_reg + 2'd1;
                        state_next = rog_pkg::BK_LOAD;
                    end
                end
                else
                begin
                    if (!c_at_last)
                    begin
                        cur_c_next = c_step;
                    end
                    else if (!r_at_last)
                    begin
                        cur_c_next = ph_reg.c_first;
                        cur_r_next = r_step;
                    end
                    else
                    begin
                        p_next = p_reg + 2'd1;
                        state_next = rog_pkg::BK_LOAD;
                    end
                end
            end
            rog_pkg::BK_FINISH:
            begin
                if (!vld_b_reg)
                begin
                    if (sweep_reg)
                    begin
                        sweep_next = 1'b0;
                        state_next = rog_pkg::BK_IDLE;
                    end
                    else
                    begin
                        state_next = rog_pkg::BK_DONE;
                    end
                end
            end
            rog_pkg::BK_DONE:
            begin
                if (!rsp_valid_next)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_hit_next = 8'(hit_reg);
                    rsp_bad_next = job_reg.bad_dir;
                    state_next = rog_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rog_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rog_pkg::BK_LOAD;
            p_reg <= 2'd0;
            dims_w_reg <= RST_W;
            dims_h_reg <= RST_H;
            found_reg <= 1'b0;
            sweep_reg <= 1'b1;
            vld_b_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg <= p_next;
            dims_w_reg <= dims_w_next;
            dims_h_reg <= dims_h_next;
            found_reg <= found_next;
            sweep_reg <= sweep_next;
            vld_b_reg <= vld_b_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        ph_reg <= ph_next;
        cur_r_reg <= cur_r_next;
        cur_c_reg <= cur_c_next;
        hit_reg <= hit_next;
        oob_b_reg <= oob_b_next;
        rsp_hit_reg <= rsp_hit_next;
        rsp_bad_reg <= rsp_bad_next;
    end

`ifndef SYNTHESIS
    a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("Grid memory was written and read in the same cycle.");

    a_readback_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        vld_b_reg |-> $past(state_reg == rog_pkg::BK_RUN))
        else $error("Scan read data arrived without a preceding walk cycle.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == rog_pkg::BK_DONE))
        else $error("A result was raised outside the completion state.");

    a_no_pop_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !sweep_reg)
        else $error("A job was taken while the reset clearing pass was running.");
`endif

endmodule
